@@ hdl/idwf_pkg.sv @@
package idwf_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] ADDR_RESET   = 8'h78;
  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  localparam logic       ACT_COMMAND = 1'b0;
  localparam logic       ACT_DATA    = 1'b1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BIT   = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_STOP  = 2'd3;

  localparam logic       REG_DEVICE_ADDRESS = 1'b0;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] payload;
  } frame_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       level;
    logic       last;
  } symbol_t;

endpackage

@@ hdl/i2c_display_write_framer.sv @@
// Frames one I2C display write per request: start, address byte, control byte
// (0x00 command, 0x40 data), payload byte, each byte followed by an ack clock,
// then stop; 29 symbols, one per clock, presented for exactly one cycle with
// out_strobe and never held off. A request is taken when start is high and
// busy is low; a two-deep request queue feeds the symbol sequencer, which
// chains frames with no gap. A taken request is written into the queue and
// popped once the sequencer is free, ahead of its start symbol. busy rises
// only when two requests are already waiting behind the frame on the wire.
// The device address is captured when a request is taken.
module i2c_display_write_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_payload,
  output logic        out_strobe,
  output logic [1:0]  out_symbol_kind,
  output logic        out_data_level,
  output logic        out_last_symbol,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]         dev_addr_r, dev_addr_nxt;
  logic               cfg_wr;
  logic               full;
  logic               q_not_empty;
  logic               q_pop;
  idwf_pkg::frame_t   frame;
  idwf_pkg::frame_t   q_head;
  idwf_pkg::symbol_t  sym;
  logic               sym_valid;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    if (cfg_wr && (paddr[2] == idwf_pkg::REG_DEVICE_ADDRESS)) begin
      dev_addr_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= idwf_pkg::ADDR_RESET;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == idwf_pkg::REG_DEVICE_ADDRESS && paddr[1:0] == 2'b00) begin
      prdata = {24'd0, dev_addr_r};
    end
  end

  assign busy = full;

  idwf_front u_front (
    .in_action      (in_action),
    .in_payload     (in_payload),
    .device_address (dev_addr_r),
    .frame          (frame)
  );

  idwf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (start),
    .push_frame (frame),
    .pop        (q_pop),
    .full       (full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  idwf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .sym_valid   (sym_valid),
    .sym         (sym)
  );

  assign out_strobe      = sym_valid;
  assign out_symbol_kind = sym.kind;
  assign out_data_level  = sym.level;
  assign out_last_symbol = sym.last;

endmodule

@@ hdl/idwf_front.sv @@
module idwf_front (
  input  logic                 in_action,
  input  logic [7:0]           in_payload,
  input  logic [7:0]           device_address,
  output idwf_pkg::frame_t     frame
);

  always_comb begin
    frame.addr    = device_address;
    frame.payload = in_payload;
    unique case (in_action)
      idwf_pkg::ACT_DATA:    frame.ctrl = idwf_pkg::CTRL_DATA;
      idwf_pkg::ACT_COMMAND: frame.ctrl = idwf_pkg::CTRL_COMMAND;
      default:               frame.ctrl = idwf_pkg::CTRL_COMMAND;
    endcase
  end

endmodule

@@ hdl/idwf_queue.sv @@
module idwf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  idwf_pkg::frame_t     push_frame,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output idwf_pkg::frame_t     head
);

  localparam int unsigned PtrW = $clog2(idwf_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(idwf_pkg::QueueDepth + 1);

  idwf_pkg::frame_t ent_r [idwf_pkg::QueueDepth];
  logic [PtrW-1:0]  wptr_r, wptr_nxt;
  logic [PtrW-1:0]  rptr_r, rptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CntW'(idwf_pkg::QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PtrW'(idwf_pkg::QueueDepth - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PtrW'(idwf_pkg::QueueDepth - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push_frame;
    end
  end

endmodule

@@ hdl/idwf_back.sv @@
module idwf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  idwf_pkg::frame_t     q_head,
  output logic                 q_pop,
  output logic                 sym_valid,
  output idwf_pkg::symbol_t    sym
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_BITS  = 3'd2;
  localparam logic [2:0] ST_ACK   = 3'd3;
  localparam logic [2:0] ST_STOP  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  bitc_r, bitc_nxt;
  logic [1:0]  bytec_r, bytec_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic        lvl_r, lvl_nxt;

  always_comb begin
    state_nxt = state_r;
    bitc_nxt  = bitc_r;
    bytec_nxt = bytec_r;
    shift_nxt = shift_r;
    lvl_nxt   = lvl_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          shift_nxt = {q_head.addr, q_head.ctrl, q_head.payload};
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        bitc_nxt  = '0;
        bytec_nxt = '0;
        state_nxt = ST_BITS;
      end
      ST_BITS: begin
        lvl_nxt   = shift_r[23];
        shift_nxt = {shift_r[22:0], 1'b0};
        bitc_nxt  = bitc_r + 1'b1;
        if (bitc_r == 3'd7) begin
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        if (bytec_r == 2'd2) begin
          state_nxt = ST_STOP;
        end else begin
          bytec_nxt = bytec_r + 1'b1;
          bitc_nxt  = '0;
          state_nxt = ST_BITS;
        end
      end
      ST_STOP: begin
        if (q_not_empty) begin
          q_pop     = 1'b1;
          shift_nxt = {q_head.addr, q_head.ctrl, q_head.payload};
          state_nxt = ST_START;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bitc_r  <= '0;
      bytec_r <= '0;
    end else begin
      state_r <= state_nxt;
      bitc_r  <= bitc_nxt;
      bytec_r <= bytec_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    lvl_r   <= lvl_nxt;
  end

  always_comb begin
    sym_valid = 1'b1;
    sym.last  = 1'b0;
    unique case (state_r)
      ST_START: begin
        sym.kind  = idwf_pkg::KIND_START;
        sym.level = 1'b0;
      end
      ST_BITS: begin
        sym.kind  = idwf_pkg::KIND_BIT;
        sym.level = shift_r[23];
      end
      ST_ACK: begin
        sym.kind  = idwf_pkg::KIND_ACK;
        sym.level = lvl_r;
      end
      ST_STOP: begin
        sym.kind  = idwf_pkg::KIND_STOP;
        sym.level = 1'b1;
        sym.last  = 1'b1;
      end
      default: begin
        sym_valid = 1'b0;
        sym.kind  = idwf_pkg::KIND_START;
        sym.level = 1'b0;
      end
    endcase
  end

endmodule

@@ dv/tb_top.sv @@
module tb_top;

  localparam int unsigned QuietLimit = 2000;
  localparam logic [2:0] ADDR_DEVICE = {idwf_pkg::REG_DEVICE_ADDRESS, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  typedef struct packed {
    logic       action;
    logic [7:0] payload;
  } write_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_action = 1'b0;
  logic [7:0]  in_payload = 8'h00;
  logic        out_strobe;
  logic [1:0]  out_symbol_kind;
  logic        out_data_level;
  logic        out_last_symbol;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  write_req_t         pending_writes[$];
  idwf_pkg::symbol_t  symbols_due[$];
  idwf_pkg::symbol_t  due_sym;
  logic [7:0]  addr_shadow = idwf_pkg::ADDR_RESET;
  int          gap_pct = 0;
  int          failures = 0;
  int          writes_taken = 0;
  int          beats_checked = 0;
  int          addr_settings = 1;
  int unsigned quiet_cycles = 0;

  i2c_display_write_framer uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_payload      (in_payload),
    .out_strobe      (out_strobe),
    .out_symbol_kind (out_symbol_kind),
    .out_data_level  (out_data_level),
    .out_last_symbol (out_last_symbol),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  function automatic void put_symbol(input logic [1:0] kind, input logic level,
                                     input logic last);
    idwf_pkg::symbol_t s;
    s.kind = kind;
    s.level = level;
    s.last = last;
    symbols_due.push_back(s);
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    for (int k = 7; k >= 0; k--) put_symbol(idwf_pkg::KIND_BIT, b[k], 1'b0);
    put_symbol(idwf_pkg::KIND_ACK, b[0], 1'b0);
  endfunction

  function automatic void frame_symbols(input logic action, input logic [7:0] payload);
    put_symbol(idwf_pkg::KIND_START, 1'b0, 1'b0);
    put_byte(addr_shadow);
    put_byte((action == idwf_pkg::ACT_DATA) ? idwf_pkg::CTRL_DATA : idwf_pkg::CTRL_COMMAND);
    put_byte(payload);
    put_symbol(idwf_pkg::KIND_STOP, 1'b1, 1'b1);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        frame_symbols(in_action, in_payload);
        void'(pending_writes.pop_front());
        writes_taken++;
      end
      if (!start || !busy) begin
        if (pending_writes.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          in_action <= pending_writes[0].action;
          in_payload <= pending_writes[0].payload;
        end else begin
          start <= 1'b0;
          in_action <= 1'($urandom);
          in_payload <= 8'($urandom);
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (symbols_due.size() == 0) begin
        $error("unexpected beat: symbol_kind %0d data_level %0d last_symbol %0d",
               out_symbol_kind, out_data_level, out_last_symbol);
        failures++;
      end else begin
        due_sym = symbols_due.pop_front();
        beats_checked++;
        if (out_symbol_kind !== due_sym.kind) begin
          $error("symbol_kind: expected %0d, got %0d", due_sym.kind, out_symbol_kind);
          failures++;
        end
        if (out_data_level !== due_sym.level) begin
          $error("data_level: expected %0d, got %0d", due_sym.level, out_data_level);
          failures++;
        end
        if (out_last_symbol !== due_sym.last) begin
          $error("last_symbol: expected %0d, got %0d", due_sym.last, out_last_symbol);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= 32'($urandom);
    if (addr == ADDR_DEVICE) begin
      addr_shadow = value;
      addr_settings++;
    end
  endtask

  task automatic cfg_check_addr();
    logic [7:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_DEVICE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== addr_shadow) begin
      $error("device_address: expected %0d, got %0d", addr_shadow, got);
      failures++;
    end
  endtask

  task automatic queue_write(input logic action, input logic [7:0] payload);
    write_req_t r;
    r.action = action;
    r.payload = payload;
    pending_writes.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_writes.size() != 0 || start || symbols_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    logic [7:0] edge_bytes[6];
    int phase_gap[4];
    int left;
    int batch;
    edge_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA};
    phase_gap = '{0, 60, 14, 0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_check_addr();

    // reset address, both actions over edge payloads
    foreach (edge_bytes[i]) begin
      queue_write(idwf_pkg::ACT_COMMAND, edge_bytes[i]);
      queue_write(idwf_pkg::ACT_DATA, edge_bytes[i]);
    end
    wait_drained();

    // address extremes
    cfg_write(ADDR_DEVICE, 8'h00);
    cfg_check_addr();
    for (int i = 0; i < 6; i++) queue_write(1'(i), edge_bytes[5 - i]);
    wait_drained();
    cfg_write(ADDR_DEVICE, 8'hFF);
    cfg_check_addr();
    for (int i = 0; i < 6; i++) queue_write(1'(i + 1), edge_bytes[i]);
    wait_drained();

    // write to an unmapped register must leave the address alone
    cfg_write(ADDR_UNMAPPED, 8'h33);
    cfg_check_addr();
    queue_write(idwf_pkg::ACT_DATA, 8'h3C);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      cfg_write(ADDR_DEVICE, 8'($urandom_range(255)));
      cfg_check_addr();
      gap_pct = phase_gap[p];
      left = 100;
      while (left > 0) begin
        // last phase feeds short bursts and lets the block drain in between
        batch = (p == 3) ? $urandom_range(8, 1) : left;
        if (batch > left) batch = left;
        for (int i = 0; i < batch; i++)
          queue_write(1'($urandom), 8'($urandom));
        left -= batch;
        if (p == 3) wait_drained();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (symbols_due.size() != 0) begin
      $error("%0d bus symbols never arrived", symbols_due.size());
      failures++;
    end
    $display("run covered %0d display writes and %0d checked bus symbols",
             writes_taken, beats_checked);
    $display("under %0d device address settings, sender gaps of 0/14/60 percent",
             addr_settings);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
